[rtl/core/psms_pkg.sv]
// Shared types and constants for the path store.
`default_nettype none
package psms_pkg;

  localparam int MAX_LEN       = 256;
  localparam int VERTEX_BITS   = 16;
  localparam int ADDR_W        = $clog2(MAX_LEN);
  localparam int LEN_W         = $clog2(MAX_LEN + 1);
  localparam int POS_W         = 8;
  localparam int CFG_W         = 17;
  localparam int OP_W          = 2;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 32;
  localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(256);

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTEND = 2'd1;
  localparam logic [OP_W-1:0] OP_MEMBER = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  typedef struct packed {
    logic                   s_we;
    logic [ADDR_W-1:0]      s_waddr;
    logic [VERTEX_BITS-1:0] s_wdata;
    logic                   s_re;
    logic [ADDR_W-1:0]      s_raddr;
    logic                   o_we;
    logic [ADDR_W-1:0]      o_waddr;
    logic [VERTEX_BITS-1:0] o_wdata;
    logic                   o_re;
    logic [ADDR_W-1:0]      o_raddr;
  } mem_req_t;

  typedef struct packed {
    logic                   accepted;
    logic                   found;
    logic [VERTEX_BITS-1:0] vertex_out;
    logic                   full_res;
  } res_t;

  typedef struct packed {
    logic [LEN_W-1:0] path_length;
    logic             is_simple;
    logic             is_cycle;
    logic             is_prime;
  } stat_t;

endpackage
`default_nettype wire

[rtl/core/psms_store.sv]
// Visit-order and sorted vertex memories with registered reads.
`default_nettype none
module psms_store (
  input  wire                               clk,
  input  psms_pkg::mem_req_t                req,
  output logic [psms_pkg::VERTEX_BITS-1:0]  sorted_rdata,
  output logic [psms_pkg::VERTEX_BITS-1:0]  order_rdata
);
  import psms_pkg::*;

  logic [VERTEX_BITS-1:0] sorted_mem [MAX_LEN];
  logic [VERTEX_BITS-1:0] order_mem  [MAX_LEN];

  always_ff @(posedge clk) begin
    if (req.s_we) begin
      sorted_mem[req.s_waddr] <= req.s_wdata;
    end
    if (req.s_re) begin
      sorted_rdata <= sorted_mem[req.s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.o_we) begin
      order_mem[req.o_waddr] <= req.o_wdata;
    end
    if (req.o_re) begin
      order_rdata <= order_mem[req.o_raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/psms_ctrl.sv]
// Sequencer for clear, order read, search, repeat check, sorted shift and insert.
`default_nettype none
module psms_ctrl (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_valid,
  input  wire  [psms_pkg::CFG_W-1:0]        cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [psms_pkg::OP_W-1:0]         in_op,
  input  wire  [psms_pkg::VERTEX_BITS-1:0]  in_vertex,
  input  wire                               in_keep,
  input  wire  [psms_pkg::POS_W-1:0]        in_position,
  output logic                              res_valid,
  input  wire                               res_ready,
  output psms_pkg::res_t                    res,
  output psms_pkg::stat_t                   stat,
  output psms_pkg::mem_req_t                req,
  input  wire  [psms_pkg::VERTEX_BITS-1:0]  sorted_rdata,
  input  wire  [psms_pkg::VERTEX_BITS-1:0]  order_rdata
);
  import psms_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD_WAIT  = 4'd1;
  localparam logic [3:0] S_SRCH_RD  = 4'd2;
  localparam logic [3:0] S_SRCH_CMP = 4'd3;
  localparam logic [3:0] S_CHK_RD   = 4'd4;
  localparam logic [3:0] S_CHK      = 4'd5;
  localparam logic [3:0] S_SHIFT    = 4'd6;
  localparam logic [3:0] S_INSERT   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]             state;
  logic [OP_W-1:0]        op_r;
  logic [VERTEX_BITS-1:0] v_r;
  logic                   keep_r;
  logic [LEN_W-1:0]       lo;
  logic [LEN_W-1:0]       hi;
  logic                   has_prev;
  logic [ADDR_W-1:0]      j;
  logic [LEN_W-1:0]       cnt;
  logic [ADDR_W-1:0]      wr_idx;
  logic                   pend;
  logic [LEN_W-1:0]       len;
  logic                   simple;
  logic                   cycle;
  logic                   prime;
  logic [CFG_W-1:0]       vcount;

  logic [LEN_W:0]         mid_sum;
  logic [LEN_W-1:0]       mid;
  logic [LEN_W-1:0]       len_inc;
  logic [LEN_W-1:0]       hi_dec;
  logic                   hit;
  logic                   pos_ok;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[LEN_W:1];
  assign len_inc  = len + 1'b1;
  assign hi_dec   = hi - 1'b1;
  assign hit      = has_prev && (sorted_rdata == v_r);
  assign pos_ok   = LEN_W'(in_position) < len;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign res_valid = (state == S_DONE);

  assign stat.path_length = len;
  assign stat.is_simple   = simple;
  assign stat.is_cycle    = cycle;
  assign stat.is_prime    = prime;

  always_comb begin
    req = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_op == OP_READ && pos_ok) begin
          req.o_re    = 1'b1;
          req.o_raddr = ADDR_W'(in_position);
        end
        if (in_valid && in_op == OP_EXTEND && len == '0) begin
          req.s_we    = 1'b1;
          req.s_waddr = '0;
          req.s_wdata = in_vertex;
          req.o_we    = 1'b1;
          req.o_waddr = '0;
          req.o_wdata = in_vertex;
        end
      end
      S_SRCH_RD: begin
        req.s_re    = (lo < hi);
        req.s_raddr = mid[ADDR_W-1:0];
      end
      S_CHK_RD: begin
        req.s_re    = (hi != '0);
        req.s_raddr = hi_dec[ADDR_W-1:0];
        req.o_re    = 1'b1;
        req.o_raddr = '0;
      end
      S_SHIFT: begin
        req.s_we    = pend;
        req.s_waddr = wr_idx;
        req.s_wdata = sorted_rdata;
        req.s_re    = (cnt != '0);
        req.s_raddr = j;
      end
      S_INSERT: begin
        req.s_we    = 1'b1;
        req.s_waddr = hi[ADDR_W-1:0];
        req.s_wdata = v_r;
        req.o_we    = 1'b1;
        req.o_waddr = len[ADDR_W-1:0];
        req.o_wdata = v_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      len    <= '0;
      simple <= 1'b1;
      cycle  <= 1'b0;
      prime  <= 1'b0;
      pend   <= 1'b0;
      vcount <= VCOUNT_RESET;
    end else begin
      if (cfg_valid) begin
        vcount <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r           <= in_op;
            v_r            <= in_vertex;
            keep_r         <= in_keep;
            res.found      <= 1'b0;
            res.vertex_out <= '0;
            lo             <= '0;
            hi             <= len;
            unique case (in_op)
              OP_CLEAR: begin
                len          <= '0;
                simple       <= 1'b1;
                cycle        <= 1'b0;
                prime        <= 1'b0;
                res.accepted <= 1'b1;
                res.full_res <= 1'b0;
                state        <= S_DONE;
              end
              OP_EXTEND: begin
                if (len == '0) begin
                  len          <= LEN_W'(1);
                  res.accepted <= 1'b1;
                  res.full_res <= 1'b0;
                  state        <= S_DONE;
                end else if (len == LEN_W'(MAX_LEN)) begin
                  res.accepted <= 1'b0;
                  res.full_res <= 1'b1;
                  state        <= S_DONE;
                end else begin
                  res.accepted <= 1'b0;
                  res.full_res <= 1'b0;
                  state        <= S_SRCH_RD;
                end
              end
              OP_MEMBER: begin
                res.accepted <= 1'b0;
                res.full_res <= 1'b0;
                state        <= S_SRCH_RD;
              end
              default: begin
                res.accepted <= 1'b0;
                res.full_res <= 1'b0;
                state        <= pos_ok ? S_RD_WAIT : S_DONE;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          res.accepted   <= 1'b1;
          res.found      <= 1'b1;
          res.vertex_out <= order_rdata;
          state          <= S_DONE;
        end
        S_SRCH_RD: begin
          state <= (lo < hi) ? S_SRCH_CMP : S_CHK_RD;
        end
        S_SRCH_CMP: begin
          if (sorted_rdata > v_r) begin
            hi <= mid;
          end else begin
            lo <= mid + 1'b1;
          end
          state <= S_SRCH_RD;
        end
        S_CHK_RD: begin
          has_prev <= (hi != '0);
          state    <= S_CHK;
        end
        S_CHK: begin
          if (op_r == OP_MEMBER) begin
            res.accepted <= 1'b1;
            res.found    <= hit;
            state        <= S_DONE;
          end else if (simple && hit && order_rdata != v_r && keep_r) begin
            state <= S_DONE;
          end else begin
            if (simple && hit) begin
              if (order_rdata == v_r) begin
                cycle <= 1'b1;
                prime <= 1'b1;
              end else begin
                simple <= 1'b0;
                prime  <= 1'b0;
              end
            end
            cnt   <= len - hi;
            j     <= ADDR_W'(len - 1'b1);
            pend  <= 1'b0;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (cnt != '0) begin
            wr_idx <= j + 1'b1;
            pend   <= 1'b1;
            j      <= j - 1'b1;
            cnt    <= cnt - 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          len <= len_inc;
          if (simple && (CFG_W'(len_inc) > vcount)) begin
            prime <= 1'b1;
          end
          res.accepted <= 1'b1;
          state        <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/path_sorted_member_store.sv]
// Top level of the path store: stream ports, output register and wiring.
// The block holds one vertex path in visit order and a sorted copy of it.
// A word on the slave side carries one operation in s_tuser: clear, extend,
// membership test or read of an order entry. Every word gives exactly one
// result word on the master side, with the path length and flags after it.
// Clear and an out-of-range read go from accept straight to the result
// state; an in-range read first waits for the registered order memory read.
// A membership test runs a binary search over the sorted memory. Extend
// adds to that a shift of the sorted entries above the new slot, one entry
// per cycle on the sorted memory port.
// Only one word is in work at a time; s_tready is low until its result has
// moved into the output register. A stalled receiver holds that register
// and, behind it, the sequencer with its result. The cfg channel sets the
// vertex count and is ready whenever reset is low. During reset both ready
// lines are low. Reset empties the path, sets the flags to simple, not
// cycle, not prime, and sets the vertex count to 256.
`default_nettype none
module path_sorted_member_store (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [psms_pkg::CFG_W-1:0]         cfg_data,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: vertex[15:0], keep_simple[16], position[24:17].
  input  wire  [psms_pkg::IN_DATA_W-1:0]     s_tdata,
  // Fields from bit 0: op[1:0].
  input  wire  [psms_pkg::OP_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // Fields from bit 0: accepted[0], found[1], vertex_out[17:2],
  // path_length[26:18], is_simple[27], is_cycle[28], is_prime[29],
  // full_res[30].
  output logic [psms_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import psms_pkg::*;

  mem_req_t               req;
  res_t                   res;
  stat_t                  stat;
  logic                   res_valid;
  logic                   res_ready;
  logic [VERTEX_BITS-1:0] sorted_rdata;
  logic [VERTEX_BITS-1:0] order_rdata;

  assign cfg_ready = !rst;
  assign res_ready = !m_tvalid || m_tready;

  psms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_op        (s_tuser),
    .in_vertex    (s_tdata[VERTEX_BITS-1:0]),
    .in_keep      (s_tdata[VERTEX_BITS]),
    .in_position  (s_tdata[VERTEX_BITS+POS_W:VERTEX_BITS+1]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .stat         (stat),
    .req          (req),
    .sorted_rdata (sorted_rdata),
    .order_rdata  (order_rdata)
  );

  psms_store u_store (
    .clk          (clk),
    .req          (req),
    .sorted_rdata (sorted_rdata),
    .order_rdata  (order_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= OUT_DATA_W'({res.full_res, stat.is_prime, stat.is_cycle,
                              stat.is_simple, stat.path_length, res.vertex_out,
                              res.found, res.accepted});
    end
  end

endmodule
`default_nettype wire
